@@ design/per_minute_pulse_logger_top_macros.svh @@
// Assertion macros shared by the pulse logger checker.
// Needs signals named clk and rst_n in the scope of use.
`ifndef PER_MINUTE_PULSE_LOGGER_TOP_MACROS_SVH
`define PER_MINUTE_PULSE_LOGGER_TOP_MACROS_SVH

// checked only out of reset
`define PML_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PML_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pml_pkg.sv @@
// Shared widths, codes and types of the per-minute pulse logger.
// No dependencies.
package pml_pkg;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int TALLY_W    = 16;
  localparam int SEC_W      = 8;
  localparam int MIN_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int WINDOW_SLOTS_DEF = 10;

  localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic REPLY_SNAP = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SECONDS = 1'b0;

  localparam logic [SEC_W-1:0] SECONDS_RESET = 8'd60;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic               reply_kind;
    logic [SLOT_W-1:0]  slot;
    logic [TALLY_W-1:0] pulse_total;
    logic               entry_valid;
    logic [SLOT_W-1:0]  stored_entries;
    logic [MIN_W-1:0]   minutes_total;
  } result_t;

endpackage

@@ design/pml_front.sv @@
// Front end: takes input beats, classifies them and pushes commands.
// Depends on pml_pkg.
module pml_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pml_pkg::OP_W-1:0]        in_operation,
  input  logic [pml_pkg::SLOT_W-1:0]      in_slot_index,
  output logic                            push_valid,
  input  logic                            push_ready,
  output pml_pkg::cmd_t                   push_cmd
);
  import pml_pkg::*;

  logic op_known;

  // unused opcode is accepted and dropped here
  assign op_known = (in_operation == OP_PULSE) || (in_operation == OP_TICK) ||
                    (in_operation == OP_READ);

  assign in_ready     = push_ready;
  assign push_valid   = in_valid && op_known;
  assign push_cmd.op  = in_operation;
  assign push_cmd.idx = in_slot_index;

endmodule

@@ design/pml_queue.sv @@
// Two-entry command queue between front and back ends.
// Depends on pml_pkg.
module pml_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  pml_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output pml_pkg::cmd_t pop_cmd
);
  import pml_pkg::*;

  cmd_t       entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_fire, pop_fire;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push_fire ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 2'd1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/pml_back.sv @@
// Back end: counters, slot window and the output register.
// Depends on pml_pkg.
module pml_back #(
  parameter int WINDOW_SLOTS = pml_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pml_pkg::SEC_W-1:0]  seconds_per_interval,
  input  logic                       cmd_valid,
  input  pml_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pml_pkg::result_t           out_result
);
  import pml_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOTS    = SLOT_W'(WINDOW_SLOTS);

  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0]  entries_r, entries_nxt;
  logic [MIN_W-1:0]   minutes_r, minutes_nxt;
  logic [TALLY_W-1:0] window_r [WINDOW_SLOTS];

  logic               out_valid_r, out_valid_nxt;
  result_t            result_r, result_nxt;

  logic               out_free, load, store_wr;
  logic [SEC_W-1:0]   sec_inc;
  logic               done;
  logic               rd_hit;

  assign out_free = !out_valid_r || out_ready;
  // pulses never produce a result, so they drain past a stalled output
  assign cmd_pop  = cmd_valid && ((cmd.op == OP_PULSE) || out_free);
  assign sec_inc  = sec_r + SEC_W'(1);
  assign done     = !(sec_inc < seconds_per_interval);
  assign rd_hit   = (cmd.idx < entries_r) && (cmd.idx < SLOTS);

  always_comb begin
    tally_nxt   = tally_r;
    sec_nxt     = sec_r;
    pos_nxt     = pos_r;
    entries_nxt = entries_r;
    minutes_nxt = minutes_r;
    load        = 1'b0;
    store_wr    = 1'b0;
    result_nxt  = result_r;
    if (cmd_pop) begin
      unique case (cmd.op)
        OP_PULSE: begin
          tally_nxt = tally_r + TALLY_W'(1);
        end
        OP_TICK: begin
          sec_nxt = sec_inc;
          if (done) begin
            sec_nxt                   = '0;
            store_wr                  = 1'b1;
            tally_nxt                 = '0;
            entries_nxt               = pos_r + SLOT_W'(1);
            pos_nxt                   = (pos_r == LAST_POS) ? '0 : pos_r + SLOT_W'(1);
            minutes_nxt               = minutes_r + MIN_W'(1);
            load                      = 1'b1;
            result_nxt.reply_kind     = REPLY_SNAP;
            result_nxt.slot           = pos_r;
            result_nxt.pulse_total    = tally_r;
            result_nxt.entry_valid    = 1'b1;
            result_nxt.stored_entries = pos_r + SLOT_W'(1);
            result_nxt.minutes_total  = minutes_r + MIN_W'(1);
          end
        end
        OP_READ: begin
          load                      = 1'b1;
          result_nxt.reply_kind     = REPLY_READ;
          result_nxt.slot           = cmd.idx;
          result_nxt.pulse_total    = rd_hit ? window_r[cmd.idx[IDX_W-1:0]] : '0;
          result_nxt.entry_valid    = rd_hit;
          result_nxt.stored_entries = entries_r;
          result_nxt.minutes_total  = minutes_r;
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= '0;
      sec_r       <= '0;
      pos_r       <= '0;
      entries_r   <= '0;
      minutes_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tally_r     <= tally_nxt;
      sec_r       <= sec_nxt;
      pos_r       <= pos_nxt;
      entries_r   <= entries_nxt;
      minutes_r   <= minutes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    if (store_wr) begin
      window_r[pos_r[IDX_W-1:0]] <= tally_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

@@ design/per_minute_pulse_logger_top.sv @@
// Per-minute pulse logger: seconds register, front end, queue, back end.
// Depends on pml_pkg, pml_front, pml_queue and pml_back.
//
// Counts pulse beats and second ticks; every seconds_per_interval ticks it
// logs the pulse tally into a rolling window of WINDOW_SLOTS slots and emits
// a snapshot beat. A read beat returns one slot (entry_valid 0 and a zero
// total past the stored count). One input beat is taken every cycle while
// in_ready is high. A result is registered: the beat is queued when accepted
// and lands in the output register when popped from the queue head. A tick
// or read waits at the queue head while a result stalls on the output;
// in_ready drops once a second beat is queued behind it. A pulse at the head
// drains even then. Operation code 3 is accepted and ignored. The seconds
// register (byte address 0, reset 60) must only be written while idle.
module per_minute_pulse_logger_top #(
  parameter int WINDOW_SLOTS = pml_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pml_pkg::OP_W-1:0]            in_operation,
  input  logic [pml_pkg::SLOT_W-1:0]          in_slot_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_reply_kind,
  output logic [pml_pkg::SLOT_W-1:0]          out_slot,
  output logic [pml_pkg::TALLY_W-1:0]         out_pulse_total,
  output logic                                out_entry_valid,
  output logic [pml_pkg::SLOT_W-1:0]          out_stored_entries,
  output logic [pml_pkg::MIN_W-1:0]           out_minutes_total,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pml_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [pml_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [pml_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import pml_pkg::*;

  logic [SEC_W-1:0] seconds_r, seconds_nxt;
  logic             cfg_wr;
  logic             push_valid, push_ready;
  cmd_t             push_cmd;
  logic             q_valid, q_pop;
  cmd_t             q_cmd;
  result_t          result;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_SECONDS);
  assign cfg_prdata = (cfg_paddr[2] == REG_SECONDS) ?
                      {{(CFG_DATA_W-SEC_W){1'b0}}, seconds_r} : '0;
  assign seconds_nxt = cfg_wr ? cfg_pwdata[SEC_W-1:0] : seconds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= SECONDS_RESET;
    end else begin
      seconds_r <= seconds_nxt;
    end
  end

  pml_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_slot_index (in_slot_index),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  pml_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  pml_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .seconds_per_interval (seconds_r),
    .cmd_valid            (q_valid),
    .cmd                  (q_cmd),
    .cmd_pop              (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result           (result)
  );

  assign out_reply_kind     = result.reply_kind;
  assign out_slot           = result.slot;
  assign out_pulse_total    = result.pulse_total;
  assign out_entry_valid    = result.entry_valid;
  assign out_stored_entries = result.stored_entries;
  assign out_minutes_total  = result.minutes_total;

endmodule

@@ design/pml_checker.sv @@
// Port-level checks on the pulse logger, bound to the top level.
// Depends on pml_pkg and per_minute_pulse_logger_top_macros.svh.
`include "per_minute_pulse_logger_top_macros.svh"

module pml_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_reply_kind,
  input logic [pml_pkg::SLOT_W-1:0]     out_slot,
  input logic [pml_pkg::TALLY_W-1:0]    out_pulse_total,
  input logic                           out_entry_valid,
  input logic [pml_pkg::SLOT_W-1:0]     out_stored_entries,
  input logic [pml_pkg::MIN_W-1:0]      out_minutes_total,
  input logic                           cfg_pready
);
  import pml_pkg::*;

  // a stalled result beat holds
  `PML_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pulse_total) && $stable(out_minutes_total) && $stable(out_slot), "result beat changed under stall")

  // snapshot always covers the slot it just wrote
  `PML_ASSERT(a_snap_count, out_valid && (out_reply_kind == REPLY_SNAP) |-> out_entry_valid && (out_stored_entries == out_slot + 4'd1), "snapshot count mismatch")

  // read replies: valid exactly below the stored count, zero total otherwise
  `PML_ASSERT(a_read_valid, out_valid && (out_reply_kind == REPLY_READ) |-> (out_entry_valid == (out_slot < out_stored_entries)) && (out_entry_valid || (out_pulse_total == '0)), "read reply validity mismatch")

  `PML_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && cfg_pready, "output valid after reset")

endmodule

bind per_minute_pulse_logger_top pml_checker u_pml_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_reply_kind     (out_reply_kind),
  .out_slot           (out_slot),
  .out_pulse_total    (out_pulse_total),
  .out_entry_valid    (out_entry_valid),
  .out_stored_entries (out_stored_entries),
  .out_minutes_total  (out_minutes_total),
  .cfg_pready         (cfg_pready)
);
